/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL modules of the presentation scheduler.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising edge outside reset.
`define VPS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication checked at every rising edge outside reset.
`define VPS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/vps_pkg.sv */
// Types, constants and codes of the presentation scheduler.
// Used by vps_frame_queue and video_presentation_scheduler; depends on nothing.
package vps_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int PTS_W = 48;
	localparam int TAG_W = 16;
	localparam int LIMIT_W = 20;
	localparam int KIND_W = 3;
	localparam int QCOUNT_W = 5;
	localparam int ALU_W = PTS_W + 2;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [LIMIT_W-1:0] LATE_LIMIT_RESET = LIMIT_W'(20000);

	typedef enum logic {
		OP_ENQUEUE = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_PRESENT = 3'd0,
		KIND_DROP = 3'd1,
		KIND_START = 3'd2,
		KIND_ENQ = 3'd3,
		KIND_FULL = 3'd4,
		KIND_DONE = 3'd5
	} kind_t;

	typedef enum logic {
		REG_TIME_MODE = 1'b0,
		REG_LATE_LIMIT = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ENQ,
		ST_READ,
		ST_HEAD,
		ST_TGT,
		ST_CLK,
		ST_DIFF,
		ST_LATE,
		ST_CMP,
		ST_DONE
	} state_t;

	typedef struct packed {
		op_t op;
		logic [PTS_W-1:0] frame_pts;
		logic [TAG_W-1:0] frame_tag;
		logic [PTS_W-1:0] now_us;
		logic [PTS_W-1:0] master_time_us;
		logic master_running;
	} vps_req_t;

	typedef struct packed {
		kind_t kind;
		logic [TAG_W-1:0] out_tag;
		logic [PTS_W-1:0] out_pts;
		logic [PTS_W-1:0] lateness_us;
		logic [QCOUNT_W-1:0] queue_count;
		logic last;
	} vps_rsp_t;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [PTS_W-1:0] pts;
	} frame_entry_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
	} queue_ctrl_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic full;
		logic empty;
	} queue_status_t;

endpackage

/* hw/rtl/video_presentation_scheduler.sv */
// Sequencing: an enqueue request gives its result from ST_ENQ; a tick walks the queue through
// READ, HEAD, TGT, CLK, DIFF, LATE and CMP per released frame and ends in DONE.
// Throughput: one request at a time; the one shared 50-bit subtractor forms target,
// clock, difference, lateness and the limit compare in turn.
// Reset: asynchronous and active low; it empties the queue, clears the anchor and loads
// local mode with a late limit of 20000 us. The frame store itself is not cleared.
module video_presentation_scheduler import vps_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input vps_req_t req,
	output logic rsp_valid,
	input logic rsp_ready,
	output vps_rsp_t rsp,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [PADDR_W-1:0] paddr,
	input logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic pready
);

	state_t state_q, state_next;
	vps_req_t req_q;
	vps_rsp_t rsp_q, rsp_next;
	logic rsp_valid_q;
	logic mode_q;
	logic [LIMIT_W-1:0] limit_q;
	logic anchor_valid_q;
	logic [PTS_W-1:0] anchor_pts_q;
	logic [PTS_W-1:0] anchor_time_q;
	logic started_q;
	logic [PTS_W-1:0] mclk_q;
	logic [ALU_W-1:0] tgt_q, clk_q, diff_q, late_q;
	logic [ALU_W-1:0] alu_a, alu_b, alu_res;
	logic cfg_wr, mode_wr;
	logic out_free, emit, early;
	logic load_tgt, load_clk, load_diff, load_late, set_anchor, set_start;
	queue_ctrl_t q_ctrl;
	queue_status_t q_status;
	frame_entry_t head_entry, push_entry;
	reg_idx_t reg_idx;

	vps_frame_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(q_ctrl),
		.push_entry(push_entry),
		.head_entry(head_entry),
		.status(q_status)
	);

	assign reg_idx = reg_idx_t'(paddr[2]);
	assign cfg_wr = psel && penable && pwrite;
	assign mode_wr = cfg_wr && (reg_idx == REG_TIME_MODE);
	assign pready = 1'b1;

	always_comb begin
		unique case (reg_idx)
			REG_TIME_MODE: prdata = {(PDATA_W-1)'(0), mode_q};
			REG_LATE_LIMIT: prdata = {(PDATA_W-LIMIT_W)'(0), limit_q};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			limit_q <= LATE_LIMIT_RESET;
		end else if (cfg_wr) begin
			if (reg_idx == REG_TIME_MODE) begin
				mode_q <= pwdata[0];
			end else begin
				limit_q <= pwdata[LIMIT_W-1:0];
			end
		end
	end

	assign alu_res = alu_a - alu_b;
	assign early = !alu_res[ALU_W-1] && (alu_res != '0);
	assign out_free = !rsp_valid_q || rsp_ready;
	assign push_entry = '{tag: req_q.frame_tag, pts: req_q.frame_pts};

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (req.op == OP_ENQUEUE) begin
						state_next = ST_ENQ;
					end else if (q_status.empty) begin
						state_next = ST_DONE;
					end else begin
						state_next = ST_READ;
					end
				end
			end
			ST_ENQ: if (out_free) state_next = ST_IDLE;
			ST_READ: state_next = ST_HEAD;
			ST_HEAD: begin
				if (!(mode_q && !started_q && !out_free)) begin
					state_next = ST_TGT;
				end
			end
			ST_TGT: state_next = ST_CLK;
			ST_CLK: state_next = ST_DIFF;
			ST_DIFF: state_next = early ? ST_DONE : ST_LATE;
			ST_LATE: state_next = ST_CMP;
			ST_CMP: begin
				if (out_free) begin
					state_next = (q_status.count > CNT_W'(1)) ? ST_READ : ST_DONE;
				end
			end
			ST_DONE: if (out_free) state_next = ST_IDLE;
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready = (state_q == ST_IDLE);
		emit = 1'b0;
		rsp_next = '0;
		alu_a = '0;
		alu_b = '0;
		load_tgt = 1'b0;
		load_clk = 1'b0;
		load_diff = 1'b0;
		load_late = 1'b0;
		set_anchor = 1'b0;
		set_start = 1'b0;
		q_ctrl = '{push: 1'b0, pop: 1'b0, clear: mode_wr};
		unique case (state_q)
			ST_ENQ: begin
				emit = out_free;
				rsp_next.out_tag = req_q.frame_tag;
				rsp_next.out_pts = req_q.frame_pts;
				rsp_next.last = 1'b1;
				if (q_status.full) begin
					rsp_next.kind = KIND_FULL;
					rsp_next.queue_count = QCOUNT_W'(q_status.count);
				end else begin
					rsp_next.kind = KIND_ENQ;
					rsp_next.queue_count = QCOUNT_W'(q_status.count + CNT_W'(1));
					q_ctrl.push = out_free;
				end
			end
			ST_HEAD: begin
				if (mode_q) begin
					if (!started_q) begin
						emit = out_free;
						set_start = out_free;
						rsp_next.kind = KIND_START;
						rsp_next.out_tag = head_entry.tag;
						rsp_next.out_pts = head_entry.pts;
						rsp_next.queue_count = QCOUNT_W'(q_status.count);
					end
				end else begin
					set_anchor = !anchor_valid_q;
				end
			end
			ST_TGT: begin
				load_tgt = 1'b1;
				alu_a = {2'b00, head_entry.pts};
				alu_b = mode_q ? '0 : {2'b00, anchor_pts_q};
			end
			ST_CLK: begin
				load_clk = 1'b1;
				alu_a = mode_q ? {2'b00, mclk_q} : {2'b00, req_q.now_us};
				alu_b = mode_q ? '0 : {2'b00, anchor_time_q};
			end
			ST_DIFF: begin
				load_diff = 1'b1;
				alu_a = tgt_q;
				alu_b = clk_q;
			end
			ST_LATE: begin
				load_late = 1'b1;
				alu_a = '0;
				alu_b = diff_q;
			end
			ST_CMP: begin
				emit = out_free;
				q_ctrl.pop = out_free;
				alu_a = {(ALU_W-LIMIT_W)'(0), limit_q};
				alu_b = late_q;
				rsp_next.kind = alu_res[ALU_W-1] ? KIND_DROP : KIND_PRESENT;
				rsp_next.out_tag = head_entry.tag;
				rsp_next.out_pts = head_entry.pts;
				rsp_next.lateness_us = (late_q[ALU_W-1:PTS_W] != '0) ? '1 : late_q[PTS_W-1:0];
				rsp_next.queue_count = QCOUNT_W'(q_status.count - CNT_W'(1));
			end
			ST_DONE: begin
				emit = out_free;
				rsp_next.kind = KIND_DONE;
				rsp_next.queue_count = QCOUNT_W'(q_status.count);
				rsp_next.last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			anchor_valid_q <= 1'b0;
			started_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (mode_wr) begin
				anchor_valid_q <= 1'b0;
			end else if (set_anchor) begin
				anchor_valid_q <= 1'b1;
			end
			if (req_valid && req_ready) begin
				started_q <= req.master_running;
			end else if (set_start) begin
				started_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req;
			mclk_q <= req.master_time_us;
		end else if (set_start) begin
			mclk_q <= head_entry.pts;
		end
		if (emit) begin
			rsp_q <= rsp_next;
		end
		if (set_anchor) begin
			anchor_pts_q <= head_entry.pts;
			anchor_time_q <= req_q.now_us;
		end
		if (load_tgt) begin
			tgt_q <= alu_res;
		end
		if (load_clk) begin
			clk_q <= {2'b00, alu_res[PTS_W-1:0]};
		end
		if (load_diff) begin
			diff_q <= alu_res;
		end
		if (load_late) begin
			late_q <= alu_res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

/* hw/rtl/vps_frame_queue.sv */
// Circular frame store with head and tail pointers and a held count.
// Depends on vps_pkg and assert_macros.svh; the head entry is read into a register.
`include "assert_macros.svh"

module vps_frame_queue import vps_pkg::*; (
	input logic clk,
	input logic arst_n,
	input queue_ctrl_t ctrl,
	input frame_entry_t push_entry,
	output frame_entry_t head_entry,
	output queue_status_t status
);

	frame_entry_t mem [QUEUE_DEPTH];
	frame_entry_t head_entry_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		ptr_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem[tail_q] <= push_entry;
		end
		head_entry_q <= mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
		end else if (ctrl.clear) begin
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
		end else begin
			if (ctrl.push) begin
				tail_q <= ptr_next(tail_q);
			end
			if (ctrl.pop) begin
				head_q <= ptr_next(head_q);
			end
			if (ctrl.push && !ctrl.pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctrl.pop && !ctrl.push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	assign head_entry = head_entry_q;
	assign status.count = count_q;
	assign status.full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

	`VPS_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_W'(QUEUE_DEPTH), "queue count exceeds depth")
	`VPS_ASSERT_IMPL(a_no_push_full, clk, arst_n, ctrl.push && !ctrl.clear, !status.full, "push into full queue")
	`VPS_ASSERT_IMPL(a_no_pop_empty, clk, arst_n, ctrl.pop && !ctrl.clear, !status.empty, "pop from empty queue")
	`VPS_ASSERT_IMPL(a_pop_step, clk, arst_n, ctrl.pop && !ctrl.push && !ctrl.clear, ##1 count_q == $past(count_q) - CNT_W'(1), "pop did not lower the count")

endmodule

/* dv/vps_schedule_checker.sv */
`timescale 1ns / 100ps
// Response checker for video_presentation_scheduler: it follows the request, response and
// register channels, predicts every response from its own frame queue and counts mismatches.
// Depends on vps_pkg only.
module vps_schedule_checker import vps_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input vps_req_t req,
	input logic rsp_valid,
	input logic rsp_ready,
	input vps_rsp_t rsp,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic pready,
	input logic [PADDR_W-1:0] paddr,
	input logic [PDATA_W-1:0] pwdata,
	input logic [PDATA_W-1:0] prdata,
	output int fail_count,
	output int pending
);

	localparam logic [PADDR_W-1:0] ADDR_TIME_MODE = PADDR_W'(4 * REG_TIME_MODE);
	localparam logic [PADDR_W-1:0] ADDR_LATE_LIMIT = PADDR_W'(4 * REG_LATE_LIMIT);
	localparam logic [63:0] LATE_MAX = 64'h0000_FFFF_FFFF_FFFF;

	frame_entry_t frames [QUEUE_DEPTH];
	logic [PTR_W-1:0] rd_ptr;
	logic [PTR_W-1:0] wr_ptr;
	logic [CNT_W-1:0] held;
	logic anchored;
	logic [PTS_W-1:0] anchor_pts;
	logic [PTS_W-1:0] anchor_now;
	logic time_mode;
	logic [LIMIT_W-1:0] late_limit;
	vps_rsp_t due_results [$];
	int reports;

	function automatic vps_rsp_t result_of(input kind_t kind, input logic [TAG_W-1:0] tag,
		input logic [PTS_W-1:0] pts, input logic [PTS_W-1:0] late,
		input logic [CNT_W-1:0] count, input logic last);
		vps_rsp_t r;
		r.kind = kind;
		r.out_tag = tag;
		r.out_pts = pts;
		r.lateness_us = late;
		r.queue_count = QCOUNT_W'(count);
		r.last = last;
		return r;
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (reports < 10) begin
			reports++;
			$display("%0t: %s", $time, msg);
		end
	endtask

	task automatic clear_frames();
		rd_ptr = '0;
		wr_ptr = '0;
		held = '0;
		anchored = 1'b0;
		anchor_pts = '0;
		anchor_now = '0;
	endtask

	task automatic schedule_request(input vps_req_t r);
		frame_entry_t head;
		logic started;
		logic walking;
		logic [PTS_W-1:0] master_clock;
		logic [PTS_W-1:0] elapsed;
		longint clk_v;
		longint tgt_v;
		longint diff_v;
		logic [63:0] late_v;
		kind_t kind;
		if (r.op == OP_ENQUEUE) begin
			if (held >= QUEUE_DEPTH) begin
				due_results.push_back(result_of(KIND_FULL, r.frame_tag, r.frame_pts, '0, held, 1'b1));
			end else begin
				frames[wr_ptr].tag = r.frame_tag;
				frames[wr_ptr].pts = r.frame_pts;
				wr_ptr = wr_ptr + 1'b1;
				held = held + 1'b1;
				due_results.push_back(result_of(KIND_ENQ, r.frame_tag, r.frame_pts, '0, held, 1'b1));
			end
		end else begin
			started = r.master_running;
			master_clock = r.master_time_us;
			walking = 1'b1;
			while (held != 0 && walking) begin
				head = frames[rd_ptr];
				if (time_mode) begin
					if (!started) begin
						started = 1'b1;
						master_clock = head.pts;
						due_results.push_back(result_of(KIND_START, head.tag, head.pts, '0, held, 1'b0));
					end
					clk_v = longint'({16'h0, master_clock});
					tgt_v = longint'({16'h0, head.pts});
				end else begin
					if (!anchored) begin
						anchored = 1'b1;
						anchor_pts = head.pts;
						anchor_now = r.now_us;
					end
					// The local counter wraps, so elapsed time is taken modulo 2^48.
					elapsed = r.now_us - anchor_now;
					clk_v = longint'({16'h0, elapsed});
					tgt_v = longint'({16'h0, head.pts}) - longint'({16'h0, anchor_pts});
				end
				diff_v = tgt_v - clk_v;
				if (diff_v > 0) begin
					walking = 1'b0;
				end else begin
					late_v = -diff_v;
					kind = (diff_v < -longint'({44'h0, late_limit})) ? KIND_DROP : KIND_PRESENT;
					if (late_v > LATE_MAX) begin
						late_v = LATE_MAX;
					end
					rd_ptr = rd_ptr + 1'b1;
					held = held - 1'b1;
					due_results.push_back(result_of(kind, head.tag, head.pts, late_v[PTS_W-1:0],
						held, 1'b0));
				end
			end
			due_results.push_back(result_of(KIND_DONE, '0, '0, '0, held, 1'b1));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		vps_rsp_t want;
		logic [PDATA_W-1:0] reg_val;
		if (!arst_n) begin
			clear_frames();
			time_mode = 1'b0;
			late_limit = LATE_LIMIT_RESET;
			due_results.delete();
			fail_count = 0;
			reports = 0;
			pending <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (due_results.size() == 0) begin
					note_failure($sformatf("unexpected response: kind %0d tag %h pts %h",
						rsp.kind, rsp.out_tag, rsp.out_pts));
				end else begin
					want = due_results.pop_front();
					if (rsp.kind !== want.kind || rsp.out_tag !== want.out_tag ||
						rsp.out_pts !== want.out_pts || rsp.lateness_us !== want.lateness_us ||
						rsp.queue_count !== want.queue_count || rsp.last !== want.last) begin
						note_failure($sformatf({"response mismatch: expected kind %0d tag %h pts %h",
							" late %h count %0d last %b, got kind %0d tag %h pts %h late %h",
							" count %0d last %b"}, want.kind, want.out_tag, want.out_pts,
							want.lateness_us, want.queue_count, want.last, rsp.kind, rsp.out_tag,
							rsp.out_pts, rsp.lateness_us, rsp.queue_count, rsp.last));
					end
				end
			end
			if (psel && penable && pready && (paddr == ADDR_TIME_MODE || paddr == ADDR_LATE_LIMIT)) begin
				if (pwrite) begin
					if (paddr == ADDR_TIME_MODE) begin
						time_mode = pwdata[0];
						clear_frames();
					end else begin
						late_limit = pwdata[LIMIT_W-1:0];
					end
				end else begin
					reg_val = (paddr == ADDR_TIME_MODE) ? PDATA_W'(time_mode) : PDATA_W'(late_limit);
					if (prdata !== reg_val) begin
						note_failure($sformatf("register read at %0d: expected %h, got %h",
							paddr, reg_val, prdata));
					end
				end
			end
			if (req_valid && req_ready) begin
				schedule_request(req);
			end
			pending <= due_results.size();
		end
	end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// Testbench top for video_presentation_scheduler: clock, reset, register settings and the
// directed and random frame and tick requests. Depends on vps_pkg, the block and the checker.
module tb_top;
	import vps_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 51;
	localparam int BURST = 18;
	localparam logic [PTS_W-1:0] PTS_MAX = '1;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	vps_req_t req;
	logic rsp_valid;
	logic rsp_ready;
	vps_rsp_t rsp;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;
	int fail_count;
	int pending;
	int cycles;
	logic calm;
	logic [PTS_W-1:0] next_pts;
	logic [PTS_W-1:0] play_now;
	logic [PTS_W-1:0] play_master;
	int unsigned step;
	logic [LIMIT_W-1:0] limit_now;

	video_presentation_scheduler dut (.*);

	vps_schedule_checker checker_i (.*);

	function automatic logic [PTS_W-1:0] rand48();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[PTS_W-1:0];
	endfunction

	task automatic send(input vps_req_t r);
		if (!calm && $urandom_range(0, 99) < 19) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic enq(input logic [PTS_W-1:0] pts, input logic [TAG_W-1:0] tag);
		vps_req_t r;
		r.op = OP_ENQUEUE;
		r.frame_pts = pts;
		r.frame_tag = tag;
		r.now_us = rand48();
		r.master_time_us = rand48();
		r.master_running = $urandom_range(0, 1);
		send(r);
	endtask

	task automatic tick(input logic [PTS_W-1:0] now, input logic [PTS_W-1:0] mtime,
		input logic running);
		vps_req_t r;
		r.op = OP_TICK;
		r.frame_pts = rand48();
		r.frame_tag = TAG_W'($urandom());
		r.now_us = now;
		r.master_time_us = mtime;
		r.master_running = running;
		send(r);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	task automatic reg_access(input reg_idx_t idx, input logic wr, input logic [PDATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= PADDR_W'(4 * idx);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_registers(input logic [PDATA_W-1:0] mode_word,
		input logic [PDATA_W-1:0] limit_word);
		drain();
		reg_access(REG_TIME_MODE, 1'b1, mode_word);
		reg_access(REG_LATE_LIMIT, 1'b1, limit_word);
		reg_access(REG_TIME_MODE, 1'b0, $urandom());
		reg_access(REG_LATE_LIMIT, 1'b0, $urandom());
		limit_now = limit_word[LIMIT_W-1:0];
	endtask

	task automatic random_item();
		vps_req_t r;
		int unsigned pick;
		int unsigned adv;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			r.op = op_t'($urandom_range(0, 1));
			r.frame_pts = rand48();
			r.frame_tag = TAG_W'($urandom());
			r.now_us = rand48();
			r.master_time_us = rand48();
			r.master_running = $urandom_range(0, 1);
			send(r);
		end else if (pick < 53) begin
			case ($urandom_range(0, 19))
				0: next_pts = next_pts - PTS_W'($urandom_range(0, 2 * limit_now + 2));
				1: next_pts = next_pts + PTS_W'($urandom_range(0, 4 * step));
				default: ;
			endcase
			enq(next_pts, TAG_W'($urandom()));
			next_pts = next_pts + PTS_W'(step) + PTS_W'($urandom_range(0, 3));
		end else begin
			adv = ($urandom_range(0, 19) == 0) ? 20 * step : $urandom_range(0, 2 * step);
			play_now = play_now + PTS_W'(adv);
			play_master = play_master + PTS_W'(adv);
			tick(play_now, play_master, $urandom_range(0, 99) < 80);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		rsp_ready <= calm || ($urandom_range(0, 99) >= 19);
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL video_presentation_scheduler");
		$finish;
	end

	initial begin
		logic [PDATA_W-1:0] mode_word;
		logic [PDATA_W-1:0] limit_word;
		int first;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		rsp_ready <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		calm <= 1'b0;
		limit_now = LATE_LIMIT_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		reg_access(REG_TIME_MODE, 1'b0, '0);
		reg_access(REG_LATE_LIMIT, 1'b0, '0);

		// Local mode: anchoring, an early frame, wrap of the local counter and saturated lateness.
		tick(rand48(), rand48(), 1'b1);
		enq(48'd1000, 16'h0001);
		enq(48'd2000, 16'h0002);
		enq(PTS_MAX, 16'hFFFF);
		enq('0, '0);
		tick(48'd5000, rand48(), 1'b0);
		tick(48'd6500, rand48(), 1'b1);
		tick(48'd4000, rand48(), 1'b0);

		// A zero late limit drops any frame that is late at all.
		set_registers(32'hFFFF_0000, 32'hABC0_0000);
		enq(48'd500, 16'h00A0);
		enq(48'd500, 16'h00B0);
		enq(48'd501, 16'h00C0);
		tick(48'd100, rand48(), 1'b0);
		tick(48'd102, rand48(), 1'b1);

		// Master mode: no start on an empty queue, start from the head frame, then a drop.
		set_registers(32'h0000_0001, 32'd1000000);
		tick(rand48(), 48'd999999, 1'b0);
		enq(48'd100, 16'h0005);
		enq(48'd300, 16'h0006);
		enq(48'd400, 16'h0007);
		tick(rand48(), 48'd999999, 1'b0);
		tick(rand48(), 48'd350, 1'b1);
		tick(rand48(), 48'd1000401, 1'b1);
		set_registers(32'h0000_0001, 32'hFFFF_FFFF);
		enq('0, 16'h0009);
		tick(rand48(), 48'hF_FFFF, 1'b1);
		enq(48'd5, 16'h000A);

		// Writing the mode register empties the queue.
		set_registers(32'hFFFF_FFFE, 32'd20000);
		tick(rand48(), rand48(), 1'b0);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: limit_word = 32'd0;
				1: limit_word = 32'd1000000;
				2: limit_word = 32'h000F_FFFF;
				4: limit_word = 32'd20000;
				5: limit_word = 32'd1;
				7: limit_word = 32'd999;
				default: limit_word = $urandom_range(0, 1000000);
			endcase
			limit_word[PDATA_W-1:LIMIT_W] = $urandom();
			mode_word = $urandom();
			mode_word[0] = p[0];
			set_registers(mode_word, limit_word);
			calm <= (p == 3);
			next_pts = rand48();
			step = $urandom_range(1, 40000);
			play_now = rand48();
			play_master = next_pts - PTS_W'($urandom_range(0, 2 * step));
			first = 0;
			if (p == 2 || p == 6) begin
				for (int b = 0; b < BURST; b++) begin
					enq(next_pts, TAG_W'($urandom()));
					next_pts = next_pts + PTS_W'(step);
				end
				first = BURST;
			end
			for (int i = first; i < PHASE_ITEMS; i++) begin
				random_item();
				if ($urandom_range(0, 49) == 0) begin
					drain();
				end
			end
		end

		drain();
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("PASS video_presentation_scheduler");
		end else begin
			$display("FAIL video_presentation_scheduler");
		end
		$finish;
	end

endmodule
